// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/svpwm_pkg.sv
`timescale 1ns / 1ps

package svpwm_pkg;

    localparam int unsigned SVM_Q   = 15;
    localparam int unsigned SVM_ONE = 32768;

    // 1/sqrt3 and 2/sqrt3 in Q15
    localparam logic signed [31:0] K_ONE_BY_SQRT3 = 32'sd18919;
    localparam logic signed [31:0] K_TWO_BY_SQRT3 = 32'sd37837;

    localparam logic [15:0] PWM_PERIOD_RST     = 16'd1714;
    localparam logic [15:0] MAX_MODULATION_RST = 16'd31130;
    localparam logic [15:0] MOD_LIMIT          = 16'd32768;

    localparam int unsigned CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_PWM_PERIOD     = 2'd0;
    localparam cfg_index_t REG_MAX_MODULATION = 2'd1;

    typedef logic [2:0] sector_t;
    localparam sector_t SEC_1 = 3'd1;
    localparam sector_t SEC_2 = 3'd2;
    localparam sector_t SEC_3 = 3'd3;
    localparam sector_t SEC_4 = 3'd4;
    localparam sector_t SEC_5 = 3'd5;
    localparam sector_t SEC_6 = 3'd6;

    // Q15 dwell time, period product, count-domain time, and edge position widths
    typedef logic signed [17:0] qtime_t;
    typedef logic signed [34:0] qprod_t;
    typedef logic signed [19:0] count_t;
    typedef logic signed [21:0] edge_t;

endpackage

// File: rtl/space_vector_pwm_duty_calculator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Handshake              Payload
// s_        s_valid / s_ready      s_alpha, s_beta (signed Q15)
// m_        m_valid / m_ready      m_duty_a, m_duty_b, m_duty_c, m_sector
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Five register stages: beta products, sector and dwell select, period
// multiply, centering, clamp into the output register. One vector enters
// per cycle while the output is taken.
// Reset (aresetn low) empties the pipeline and reloads both registers.
// A stall on m_ready backs up stage by stage; an empty stage keeps
// accepting, so bubbles close up. cfg_ready is always high.
module space_vector_pwm_duty_calculator
    import svpwm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_alpha,
    input  logic signed [15:0] s_beta,

    output logic               m_valid,
    input  logic               m_ready,
    output logic        [15:0] m_duty_a,
    output logic        [15:0] m_duty_b,
    output logic        [15:0] m_duty_c,
    output logic        [2:0]  m_sector,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  cfg_index_t         cfg_index,
    input  logic        [15:0] cfg_data
);

    localparam int unsigned NUM_STAGES = 5;

    // configuration registers
    logic [15:0] pwm_period_reg;
    logic [15:0] max_modulation_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg     <= PWM_PERIOD_RST;
            max_modulation_reg <= MAX_MODULATION_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PWM_PERIOD:     pwm_period_reg     <= cfg_data;
                REG_MAX_MODULATION: max_modulation_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and advance enables
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // ---------------- stage 1: beta products, clamp ceiling ----------------
    logic signed [15:0] st1_alpha_reg, st1_alpha_next;
    logic signed [31:0] st1_b1p_reg,   st1_b1p_next;
    logic signed [31:0] st1_b2p_reg,   st1_b2p_next;
    logic        [15:0] st1_per_reg,   st1_per_next;
    logic        [15:0] st1_tmax_reg,  st1_tmax_next;

    logic [15:0] mm_sat;
    logic [16:0] mod_scale;
    logic [32:0] tmax_prod;

    always_comb begin
        mm_sat    = (max_modulation_reg > MOD_LIMIT) ? MOD_LIMIT : max_modulation_reg;
        mod_scale = 17'(SVM_ONE) + 17'(mm_sat);
        tmax_prod = 33'(pwm_period_reg) * 33'(mod_scale);

        st1_alpha_next = s_alpha;
        st1_b1p_next   = 32'(s_beta) * K_ONE_BY_SQRT3;
        st1_b2p_next   = 32'(s_beta) * K_TWO_BY_SQRT3;
        st1_per_next   = pwm_period_reg;
        st1_tmax_next  = tmax_prod[SVM_Q+16:SVM_Q+1];
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_alpha_reg <= st1_alpha_next;
            st1_b1p_reg   <= st1_b1p_next;
            st1_b2p_reg   <= st1_b2p_next;
            st1_per_reg   <= st1_per_next;
            st1_tmax_reg  <= st1_tmax_next;
        end
    end

    // ---------------- stage 2: sector and dwell select ----------------
    qtime_t             st2_ta_reg,   st2_ta_next;
    qtime_t             st2_tb_reg,   st2_tb_next;
    sector_t            st2_sec_reg,  st2_sec_next;
    logic        [15:0] st2_per_reg,  st2_per_next;
    logic        [15:0] st2_tmax_reg, st2_tmax_next;

    logic signed [31:0] b1_sh, b2_sh;
    qtime_t             al_x, b1_x, b2_x;
    logic               beta_neg, alpha_neg;

    always_comb begin
        b1_sh     = st1_b1p_reg >>> SVM_Q;
        b2_sh     = st1_b2p_reg >>> SVM_Q;
        al_x      = 18'(st1_alpha_reg);
        b1_x      = 18'(b1_sh);
        b2_x      = 18'(b2_sh);
        beta_neg  = st1_b1p_reg[31];
        alpha_neg = st1_alpha_reg[15];

        if (!beta_neg) begin
            if (!alpha_neg) begin
                st2_sec_next = (b1_x > al_x) ? SEC_2 : SEC_1;
            end else begin
                st2_sec_next = (-b1_x > al_x) ? SEC_3 : SEC_2;
            end
        end else begin
            if (!alpha_neg) begin
                st2_sec_next = (-b1_x > al_x) ? SEC_5 : SEC_6;
            end else begin
                st2_sec_next = (b1_x > al_x) ? SEC_4 : SEC_5;
            end
        end

        case (st2_sec_next)
            SEC_1: begin
                st2_ta_next = al_x - b1_x;
                st2_tb_next = b2_x;
            end
            SEC_2: begin
                st2_ta_next = al_x + b1_x;
                st2_tb_next = b1_x - al_x;
            end
            SEC_3: begin
                st2_ta_next = b2_x;
                st2_tb_next = -al_x - b1_x;
            end
            SEC_4: begin
                st2_ta_next = b1_x - al_x;
                st2_tb_next = -b2_x;
            end
            SEC_5: begin
                st2_ta_next = -al_x - b1_x;
                st2_tb_next = al_x - b1_x;
            end
            default: begin
                st2_ta_next = -b2_x;
                st2_tb_next = al_x + b1_x;
            end
        endcase

        st2_per_next  = st1_per_reg;
        st2_tmax_next = st1_tmax_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            st2_ta_reg   <= st2_ta_next;
            st2_tb_reg   <= st2_tb_next;
            st2_sec_reg  <= st2_sec_next;
            st2_per_reg  <= st2_per_next;
            st2_tmax_reg <= st2_tmax_next;
        end
    end

    // ---------------- stage 3: scale by period ----------------
    qprod_t             st3_pa_reg,   st3_pa_next;
    qprod_t             st3_pb_reg,   st3_pb_next;
    sector_t            st3_sec_reg,  st3_sec_next;
    logic        [15:0] st3_per_reg,  st3_per_next;
    logic        [15:0] st3_tmax_reg, st3_tmax_next;

    logic signed [16:0] per_s;

    always_comb begin
        per_s         = $signed({1'b0, st2_per_reg});
        st3_pa_next   = 35'(st2_ta_reg) * 35'(per_s);
        st3_pb_next   = 35'(st2_tb_reg) * 35'(per_s);
        st3_sec_next  = st2_sec_reg;
        st3_per_next  = st2_per_reg;
        st3_tmax_next = st2_tmax_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            st3_pa_reg   <= st3_pa_next;
            st3_pb_reg   <= st3_pb_next;
            st3_sec_reg  <= st3_sec_next;
            st3_per_reg  <= st3_per_next;
            st3_tmax_reg <= st3_tmax_next;
        end
    end

    // stage 4: center the x, y and z edge positions
    edge_t              st4_x_reg,    st4_x_next;
    edge_t              st4_y_reg,    st4_y_next;
    edge_t              st4_z_reg,    st4_z_next;
    sector_t            st4_sec_reg,  st4_sec_next;
    logic        [15:0] st4_tmax_reg, st4_tmax_next;

    qprod_t ca_sh, cb_sh;
    count_t ca, cb;
    edge_t  ca_x, cb_x, sum, sum_adj;

    always_comb begin
        ca_sh   = st3_pa_reg >>> SVM_Q;
        cb_sh   = st3_pb_reg >>> SVM_Q;
        ca      = ca_sh[19:0];
        cb      = cb_sh[19:0];
        ca_x    = 22'(ca);
        cb_x    = 22'(cb);
        sum     = $signed({6'd0, st3_per_reg}) + ca_x + cb_x;
        // halve toward zero: bias negatives up by one
        sum_adj = sum + $signed({21'd0, sum[21]});

        st4_x_next = sum_adj >>> 1;
        // odd sectors step down by the first dwell, even ones by the second
        st4_y_next = st4_x_next - (st3_sec_reg[0] ? ca_x : cb_x);
        st4_z_next = st4_x_next - (ca_x + cb_x);

        st4_sec_next  = st3_sec_reg;
        st4_tmax_next = st3_tmax_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            st4_x_reg    <= st4_x_next;
            st4_y_reg    <= st4_y_next;
            st4_z_reg    <= st4_z_next;
            st4_sec_reg  <= st4_sec_next;
            st4_tmax_reg <= st4_tmax_next;
        end
    end

    // ---------------- stage 5: phase map, clamp, output ----------------
    logic    [15:0] duty_a_reg, duty_a_next;
    logic    [15:0] duty_b_reg, duty_b_next;
    logic    [15:0] duty_c_reg, duty_c_next;
    sector_t        sector_reg, sector_next;

    edge_t ea, eb, ec, tmax_x;

    function automatic logic [15:0] clamp_edge(input edge_t v, input edge_t hi);
        logic [15:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > hi) begin
            r = hi[15:0];
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb begin
        case (st4_sec_reg)
            SEC_1: begin
                ea = st4_x_reg; eb = st4_y_reg; ec = st4_z_reg;
            end
            SEC_2: begin
                ea = st4_y_reg; eb = st4_x_reg; ec = st4_z_reg;
            end
            SEC_3: begin
                ea = st4_z_reg; eb = st4_x_reg; ec = st4_y_reg;
            end
            SEC_4: begin
                ea = st4_z_reg; eb = st4_y_reg; ec = st4_x_reg;
            end
            SEC_5: begin
                ea = st4_y_reg; eb = st4_z_reg; ec = st4_x_reg;
            end
            default: begin
                ea = st4_x_reg; eb = st4_z_reg; ec = st4_y_reg;
            end
        endcase

        tmax_x      = $signed({6'd0, st4_tmax_reg});
        duty_a_next = clamp_edge(ea, tmax_x);
        duty_b_next = clamp_edge(eb, tmax_x);
        duty_c_next = clamp_edge(ec, tmax_x);
        sector_next = st4_sec_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            duty_c_reg <= duty_c_next;
            sector_reg <= sector_next;
        end
    end

    assign m_duty_a = duty_a_reg;
    assign m_duty_b = duty_b_reg;
    assign m_duty_c = duty_c_reg;
    assign m_sector = sector_reg;

    // ---------------- checks ----------------
    `ASSERT_CLK(a_reset_empties, aclk, !aresetn |=> !m_valid, "output valid right after reset")

    `ASSERT_CLK_RST(a_sector_range, aclk, aresetn,
        m_valid |-> (m_sector >= SEC_1 && m_sector <= SEC_6), "sector out of range")

    `ASSERT_CLK_RST(a_sector1_order, aclk, aresetn,
        (m_valid && m_sector == SEC_1) |-> (m_duty_a >= m_duty_b && m_duty_b >= m_duty_c),
        "sector 1 phase order broken")

endmodule
